[src/csem_pkg.sv]
// Shared types and constants for the counting semaphore with FIFO waiters.
`timescale 1ns / 1ps
`default_nettype none
package csem_pkg;

    localparam int NUM_TASKS = 8;
    localparam int PTR_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int LEN_W     = $clog2(NUM_TASKS + 1);
    localparam int TASK_W    = 3;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MUTEX_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOAD_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_ACQUIRED  = 3'd0,
        ST_BLOCKED   = 3'd1,
        ST_RAISED    = 3'd2,
        ST_HANDED    = 3'd3,
        ST_NOT_OWNER = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef struct packed {
        status_t             status;
        logic                woken_valid;
        logic [TASK_W-1:0]   woken_task;
    } result_t;

endpackage
`default_nettype wire

[src/csem_fifo_mem.sv]
// Wait queue storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module csem_fifo_mem (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [csem_pkg::PTR_W-1:0]    wr_addr,
    input  wire logic [csem_pkg::TASK_W-1:0]   wr_data,
    input  wire logic [csem_pkg::PTR_W-1:0]    rd_addr,
    output logic      [csem_pkg::TASK_W-1:0]   rd_data
);
    import csem_pkg::*;

    logic [TASK_W-1:0] mem_q [NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem_q[rd_addr];
    end

endmodule
`default_nettype wire

[src/csem_core.sv]
// Semaphore state, queue pointers, owner tracking and per-request decision.
`timescale 1ns / 1ps
`default_nettype none
module csem_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            exec,
    input  wire logic                            op_release,
    input  wire logic [csem_pkg::TASK_W-1:0]     op_id,
    input  wire logic                            cfg_we,
    input  wire logic [csem_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [csem_pkg::COUNT_W-1:0]    cfg_wdata,
    output csem_pkg::result_t                    result
);
    import csem_pkg::*;

    logic [COUNT_W-1:0] count_reg, count_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic               owner_valid_reg, owner_valid_next;
    logic [TASK_W-1:0]  owner_task_reg, owner_task_next;
    logic               mutex_reg, mutex_next;
    logic [COUNT_W-1:0] init_reg, init_next;

    logic [PTR_W:0]     tail_sum;
    logic [PTR_W-1:0]   tail;
    logic [PTR_W-1:0]   head_inc;
    logic               full;
    logic               wr_en;
    logic [TASK_W-1:0]  rd_data;

    csem_fifo_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (op_id),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        tail_sum = (PTR_W+1)'(head_reg) + (PTR_W+1)'(len_reg);
        if (tail_sum >= (PTR_W+1)'(NUM_TASKS))
        begin
            tail_sum = tail_sum - (PTR_W+1)'(NUM_TASKS);
        end
        tail     = tail_sum[PTR_W-1:0];
        head_inc = (head_reg == PTR_W'(NUM_TASKS - 1)) ? '0 : head_reg + 1'b1;
        full     = (len_reg == LEN_W'(NUM_TASKS));
    end

    always_comb
    begin
        count_next       = count_reg;
        len_next         = len_reg;
        head_next        = head_reg;
        owner_valid_next = owner_valid_reg;
        owner_task_next  = owner_task_reg;
        mutex_next       = mutex_reg;
        init_next        = init_reg;
        wr_en            = 1'b0;
        result.status      = ST_ACQUIRED;
        result.woken_valid = 1'b0;
        result.woken_task  = '0;

        if (!op_release)
        begin
            if (count_reg != '0)
            begin
                result.status = ST_ACQUIRED;
                if (exec)
                begin
                    count_next = count_reg - 1'b1;
                    if (mutex_reg)
                    begin
                        owner_valid_next = 1'b1;
                        owner_task_next  = op_id;
                    end
                end
            end
            else if (full)
            begin
                result.status = ST_FULL;
            end
            else
            begin
                result.status = ST_BLOCKED;
                if (exec)
                begin
                    wr_en    = 1'b1;
                    len_next = len_reg + 1'b1;
                end
            end
        end
        else if (mutex_reg && (!owner_valid_reg || owner_task_reg != op_id))
        begin
            result.status = ST_NOT_OWNER;
        end
        else if (len_reg != '0)
        begin
            result.status      = ST_HANDED;
            result.woken_valid = 1'b1;
            result.woken_task  = rd_data;
            if (exec)
            begin
                head_next = head_inc;
                len_next  = len_reg - 1'b1;
                if (mutex_reg)
                begin
                    owner_valid_next = 1'b1;
                    owner_task_next  = rd_data;
                end
            end
        end
        else
        begin
            result.status = ST_RAISED;
            if (exec)
            begin
                if (mutex_reg)
                begin
                    owner_valid_next = 1'b0;
                end
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end

        if (cfg_we)
        begin
            case (cfg_idx)
                CFG_MUTEX_MODE:
                begin
                    mutex_next = cfg_wdata[0];
                end
                CFG_LOAD_COUNT:
                begin
                    init_next = cfg_wdata;
                end
                default:
                begin
                    init_next = init_reg;
                end
            endcase
            count_next       = mutex_next ? COUNT_W'(1) : init_next;
            len_next         = '0;
            head_next        = '0;
            owner_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            len_reg         <= '0;
            head_reg        <= '0;
            owner_valid_reg <= 1'b0;
            mutex_reg       <= 1'b0;
            init_reg        <= '0;
        end
        else
        begin
            count_reg       <= count_next;
            len_reg         <= len_next;
            head_reg        <= head_next;
            owner_valid_reg <= owner_valid_next;
            mutex_reg       <= mutex_next;
            init_reg        <= init_next;
        end
    end

    always_ff @(posedge clk)
    begin
        owner_task_reg <= owner_task_next;
    end

endmodule
`default_nettype wire

[src/counting_semaphore_fifo_waiters.sv]
// Top level: request sequencing, configuration port and result register.
//
// Counting semaphore with a FIFO of blocked task ids and an optional mutex mode.
// Request channel (in_valid/in_ready, mode, task_id): mode 0 waits or
// acquires, mode 1 signals or releases. Each request yields exactly one
// result on the result channel (out_valid/out_ready, status, woken_valid,
// woken_task).
// A request is taken in S_IDLE, where the transfer issues the read of the
// queue head from the wait memory; S_EXEC uses the registered head entry,
// updates state and loads the result register.
// No new request is accepted until the current one has left S_EXEC; the
// result is marked valid in the result register as S_EXEC completes.
// The result register lets a new request transfer while a result still
// waits; if the receiver stalls with a result pending, the next request
// holds in its execute cycle until out_ready frees the register.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is taken only
// while no request is in flight; any write reloads the count (1 in mutex
// mode, else the programmed start count) and clears the queue and owner.
// Reset: mutex mode off, count zero, queue empty, no owner.
`timescale 1ns / 1ps
`default_nettype none
module counting_semaphore_fifo_waiters (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            mode,
    input  wire logic [csem_pkg::TASK_W-1:0]     task_id,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [2:0]                      status,
    output logic                                 woken_valid,
    output logic      [csem_pkg::TASK_W-1:0]     woken_task,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [csem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [csem_pkg::COUNT_W-1:0]    cfg_data
);
    import csem_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic              op_reg;
    logic [TASK_W-1:0] id_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;
    logic              in_xfer;
    logic              exec;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign exec      = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    csem_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .exec       (exec),
        .op_release (op_reg),
        .op_id      (id_reg),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .result     (result)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg <= mode;
            id_reg <= task_id;
        end
        if (exec)
        begin
            out_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign woken_valid = out_reg.woken_valid;
    assign woken_task  = out_reg.woken_task;

endmodule
`default_nettype wire
